// File: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the pressure compensation block
// Holds the operand codes, the multiply-accumulate program and helpers.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int REQ_W       = 48;
   localparam int RSP_W       = 40;
   localparam int CSR_W       = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int CAL_HIGH_W  = 40;
   localparam int CAL_W       = 168;
   localparam int RAW_W       = 24;
   localparam int DELTA_W     = 25;
   localparam int TEMP_W      = 16;
   localparam int PRESS_W     = 24;
   localparam int ACC_W       = 224;
   localparam int MAG_W       = 160;
   localparam int LIMB_W      = 32;
   localparam int LIMB_LOG    = 5;
   localparam int SH_W        = 8;
   localparam int CNT_W       = 3;
   localparam int PC_W        = 5;
   localparam int COEF_W      = 18;
   localparam int QUEUE_DEPTH = 2;
   localparam int SRC_COUNT   = 21;
   localparam int T_DEN_BITS  = 48;
   localparam int P_DEN_BITS  = 181;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW,
      CSR_MID,
      CSR_HIGH
   } csr_type;

   typedef enum logic [4:0] {
      SRC_ONE, SRC_D, SRC_PR, SRC_T2, SRC_T3, SRC_Q1, SRC_Q2,
      SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9, SRC_P10, SRC_P11,
      SRC_DD, SRC_N, SRC_PSQ, SRC_PCUBE, SRC_H
   } src_type;

   typedef enum logic [2:0] {
      DST_NONE, DST_DD, DST_N, DST_PSQ, DST_PCUBE, DST_H, DST_OUT
   } dst_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_ISSUE, ST_WAIT, ST_STORE
   } state_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } operand_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] delta_t;
      logic [RAW_W-1:0]          press;
   } item_type;

   typedef struct packed {
      logic             clr;
      src_type          src_x;
      logic [CNT_W-1:0] last_x;
      src_type          src_y;
      logic [CNT_W-1:0] last_y;
      logic [SH_W-1:0]  sh;
      dst_type          dst;
   } inst_type;

   // Horner form in the temperature: s = c0 + n*(c1 + n*(c2 + n*c3))
   function automatic inst_type prog(input logic [PC_W-1:0] pc);
      inst_type r;
      case (pc)
         5'd0:  r = '{1'b1, SRC_D,   3'd0, SRC_D,     3'd0, 8'd0,   DST_DD};
         5'd1:  r = '{1'b1, SRC_D,   3'd0, SRC_T2,    3'd0, 8'd18,  DST_NONE};
         5'd2:  r = '{1'b0, SRC_DD,  3'd1, SRC_T3,    3'd0, 8'd0,   DST_N};
         5'd3:  r = '{1'b1, SRC_PR,  3'd0, SRC_PR,    3'd0, 8'd0,   DST_PSQ};
         5'd4:  r = '{1'b1, SRC_PSQ, 3'd1, SRC_PR,    3'd0, 8'd0,   DST_PCUBE};
         5'd5:  r = '{1'b1, SRC_P8,  3'd0, SRC_ONE,   3'd0, 8'd22,  DST_NONE};
         5'd6:  r = '{1'b0, SRC_P4,  3'd0, SRC_PR,    3'd0, 8'd0,   DST_H};
         5'd7:  r = '{1'b1, SRC_P7,  3'd0, SRC_ONE,   3'd0, 8'd77,  DST_NONE};
         5'd8:  r = '{1'b0, SRC_P3,  3'd0, SRC_PR,    3'd0, 8'd53,  DST_NONE};
         5'd9:  r = '{1'b0, SRC_N,   3'd1, SRC_H,     3'd0, 8'd0,   DST_H};
         5'd10: r = '{1'b1, SRC_P6,  3'd0, SRC_ONE,   3'd0, 8'd127, DST_NONE};
         5'd11: r = '{1'b0, SRC_Q2,  3'd0, SRC_PR,    3'd0, 8'd104, DST_NONE};
         5'd12: r = '{1'b0, SRC_P10, 3'd0, SRC_PSQ,   3'd1, 8'd85,  DST_NONE};
         5'd13: r = '{1'b0, SRC_N,   3'd1, SRC_H,     3'd2, 8'd0,   DST_H};
         5'd14: r = '{1'b1, SRC_P5,  3'd0, SRC_ONE,   3'd0, 8'd184, DST_NONE};
         5'd15: r = '{1'b0, SRC_Q1,  3'd0, SRC_PR,    3'd0, 8'd161, DST_NONE};
         5'd16: r = '{1'b0, SRC_P9,  3'd0, SRC_PSQ,   3'd1, 8'd133, DST_NONE};
         5'd17: r = '{1'b0, SRC_P11, 3'd0, SRC_PCUBE, 3'd2, 8'd116, DST_NONE};
         5'd18: r = '{1'b0, SRC_N,   3'd1, SRC_H,     3'd4, 8'd0,   DST_OUT};
         default: r = '{1'b1, SRC_ONE, 3'd0, SRC_ONE, 3'd0, 8'd0, DST_OUT};
      endcase
      return r;
   endfunction

   function automatic operand_type coef_op(input logic signed [COEF_W-1:0] c);
      operand_type r;
      logic [COEF_W-1:0] a;
      a = c[COEF_W-1] ? (~c + COEF_W'(1)) : c;
      r.neg = c[COEF_W-1];
      r.mag = MAG_W'(a);
      return r;
   endfunction

endpackage

// File: rtl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: input stage
// Accepts raw words, forms the temperature offset and hands items to the queue.
// ----------------------------------------------------------------------------
module bpc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [15:0]                cal_t1,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bpc_pkg::REQ_W-1:0]  req_tdata,   // raw_pressure, raw_temperature
   output logic                       f_valid,
   output bpc_pkg::item_type          f_item,
   input  logic                       f_ready
);
   import bpc_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   assign req_tready = !valid_ff || f_ready;
   assign f_valid    = valid_ff;
   assign f_item     = item_ff;

   always_comb begin
      item_in.press   = req_tdata[RAW_W-1:0];
      item_in.delta_t = signed'({1'b0, req_tdata[2*RAW_W-1:RAW_W]})
                      - signed'({1'b0, cal_t1, 8'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: rtl/bpc_queue.sv
// ----------------------------------------------------------------------------
// bpc_queue: short item queue
// Decouples the input stage from the arithmetic sequencer.
// ----------------------------------------------------------------------------
module bpc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bpc_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output bpc_pkg::item_type out_item
);
   import bpc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              push, pop;

   assign in_ready  = count_ff != CNT_QW'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: rtl/bpc_engine.sv
// ----------------------------------------------------------------------------
// bpc_engine: exact polynomial evaluation
// Runs a fixed multiply-accumulate program through one 32x32 multiplier,
// then rounds and saturates both results into the output register.
// ----------------------------------------------------------------------------
module bpc_engine #(
   parameter int TEMP_FRAC_BITS  = 8,
   parameter int PRESS_FRAC_BITS = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bpc_pkg::CAL_W-1:0]  cal_bytes,
   input  logic                       q_valid,
   input  bpc_pkg::item_type          q_item,
   output logic                       q_ready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bpc_pkg::RSP_W-1:0]  rsp_tdata
);
   import bpc_pkg::*;

   localparam int TSH = T_DEN_BITS - TEMP_FRAC_BITS;
   localparam int PSH = P_DEN_BITS - PRESS_FRAC_BITS;
   localparam logic signed [63:0] T_HALF = 64'sd1 <<< (TSH - 1);
   localparam logic signed [63:0] T_MAX  = 64'sd32767;
   localparam logic signed [63:0] T_MIN  = -64'sd32768;
   localparam logic signed [ACC_W-1:0] P_HALF = ACC_W'(1) << (PSH - 1);
   localparam logic signed [ACC_W-1:0] P_MAX  = (ACC_W'(1) << PRESS_W) - ACC_W'(1);

   state_type                 state_ff, state_in;
   logic [PC_W-1:0]           pc_ff, pc_in;
   logic [CNT_W-1:0]          li_ff, li_in, lj_ff, lj_in;
   logic signed [DELTA_W-1:0] delta_ff;
   logic [RAW_W-1:0]          press_ff;
   logic [63:0]               dd_ff, n_ff, psq_ff;
   logic [95:0]               pcube_ff;
   logic [MAG_W-1:0]          h_ff;
   logic                      dd_neg_ff, n_neg_ff, psq_neg_ff, pcube_neg_ff, h_neg_ff;
   logic                      pp_valid_ff, pp_neg_ff, pp_clr_ff;
   logic [63:0]               pp_ff;
   logic [SH_W-1:0]           pp_sh_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff;
   logic [RSP_W-1:0]          rsp_data_ff;
   logic signed [TEMP_W-1:0]  temp_ff;

   inst_type                  inst;
   operand_type               bank [SRC_COUNT];
   operand_type               x_op, y_op;
   logic [LIMB_W-1:0]         x_limb, y_limb;
   logic [63:0]               pp_in;
   logic                      issue, store, finish;
   logic [DELTA_W-1:0]        delta_abs;
   logic signed [COEF_W-1:0]  c_t2, c_t3, c_q1, c_q2, c_p3, c_p4, c_p5, c_p6;
   logic signed [COEF_W-1:0]  c_p7, c_p8, c_p9, c_p10, c_p11;
   logic [ACC_W-1:0]          addend, base;
   logic                      st_neg;
   logic [MAG_W-1:0]          st_mag;
   logic signed [63:0]        t_sum, t_wide;
   logic signed [TEMP_W-1:0]  temp_sat;
   logic signed [ACC_W-1:0]   p_sum, p_wide;
   logic [PRESS_W-1:0]        press_sat;

   assign inst       = prog(pc_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      c_t2  = COEF_W'({1'b0, cal_bytes[31:16]});
      c_t3  = COEF_W'(signed'(cal_bytes[39:32]));
      c_q1  = COEF_W'(signed'(cal_bytes[55:40])) - COEF_W'(16384);
      c_q2  = COEF_W'(signed'(cal_bytes[71:56])) - COEF_W'(16384);
      c_p3  = COEF_W'(signed'(cal_bytes[79:72]));
      c_p4  = COEF_W'(signed'(cal_bytes[87:80]));
      c_p5  = COEF_W'({1'b0, cal_bytes[103:88]});
      c_p6  = COEF_W'({1'b0, cal_bytes[119:104]});
      c_p7  = COEF_W'(signed'(cal_bytes[127:120]));
      c_p8  = COEF_W'(signed'(cal_bytes[135:128]));
      c_p9  = COEF_W'(signed'(cal_bytes[151:136]));
      c_p10 = COEF_W'(signed'(cal_bytes[159:152]));
      c_p11 = COEF_W'(signed'(cal_bytes[167:160]));
      delta_abs = delta_ff[DELTA_W-1] ? (~delta_ff + 1'b1) : delta_ff;

      bank[SRC_ONE]   = '{neg: 1'b0, mag: MAG_W'(1)};
      bank[SRC_D]     = '{neg: delta_ff[DELTA_W-1], mag: MAG_W'(delta_abs)};
      bank[SRC_PR]    = '{neg: 1'b0, mag: MAG_W'(press_ff)};
      bank[SRC_T2]    = coef_op(c_t2);
      bank[SRC_T3]    = coef_op(c_t3);
      bank[SRC_Q1]    = coef_op(c_q1);
      bank[SRC_Q2]    = coef_op(c_q2);
      bank[SRC_P3]    = coef_op(c_p3);
      bank[SRC_P4]    = coef_op(c_p4);
      bank[SRC_P5]    = coef_op(c_p5);
      bank[SRC_P6]    = coef_op(c_p6);
      bank[SRC_P7]    = coef_op(c_p7);
      bank[SRC_P8]    = coef_op(c_p8);
      bank[SRC_P9]    = coef_op(c_p9);
      bank[SRC_P10]   = coef_op(c_p10);
      bank[SRC_P11]   = coef_op(c_p11);
      bank[SRC_DD]    = '{neg: dd_neg_ff, mag: MAG_W'(dd_ff)};
      bank[SRC_N]     = '{neg: n_neg_ff, mag: MAG_W'(n_ff)};
      bank[SRC_PSQ]   = '{neg: psq_neg_ff, mag: MAG_W'(psq_ff)};
      bank[SRC_PCUBE] = '{neg: pcube_neg_ff, mag: MAG_W'(pcube_ff)};
      bank[SRC_H]     = '{neg: h_neg_ff, mag: h_ff};

      x_op   = bank[inst.src_x];
      y_op   = bank[inst.src_y];
      x_limb = x_op.mag[li_ff*LIMB_W +: LIMB_W];
      y_limb = y_op.mag[lj_ff*LIMB_W +: LIMB_W];
      pp_in  = x_limb * y_limb;
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      li_in    = li_ff;
      lj_in    = lj_ff;
      q_ready  = 1'b0;
      issue    = 1'b0;
      store    = 1'b0;
      finish   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               state_in = ST_ISSUE;
               pc_in    = '0;
               li_in    = '0;
               lj_in    = '0;
            end
         end
         ST_ISSUE: begin
            issue = 1'b1;
            if (lj_ff != inst.last_y) begin
               lj_in = lj_ff + 1'b1;
            end else begin
               lj_in = '0;
               if (li_ff != inst.last_x) begin
                  li_in = li_ff + 1'b1;
               end else begin
                  li_in = '0;
                  if (inst.dst != DST_NONE) begin
                     state_in = ST_WAIT;
                  end else begin
                     pc_in = pc_ff + 1'b1;
                  end
               end
            end
         end
         ST_WAIT: begin
            state_in = ST_STORE;
         end
         ST_STORE: begin
            if (inst.dst == DST_OUT) begin
               if (!rsp_valid_ff || rsp_tready) begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               store    = 1'b1;
               pc_in    = pc_ff + 1'b1;
               state_in = ST_ISSUE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      addend = ACC_W'(pp_ff) << pp_sh_ff;
      base   = pp_clr_ff ? '0 : acc_ff;
      acc_in = base + (addend ^ {ACC_W{pp_neg_ff}}) + ACC_W'(pp_neg_ff);

      st_neg = acc_ff[ACC_W-1];
      st_mag = st_neg ? (~acc_ff[MAG_W-1:0] + 1'b1) : acc_ff[MAG_W-1:0];

      t_sum  = acc_ff[63:0] + T_HALF;
      t_wide = t_sum >>> TSH;
      if (t_wide > T_MAX) begin
         temp_sat = 16'sh7FFF;
      end else if (t_wide < T_MIN) begin
         temp_sat = 16'sh8000;
      end else begin
         temp_sat = t_wide[TEMP_W-1:0];
      end

      p_sum  = acc_ff + P_HALF;
      p_wide = p_sum >>> PSH;
      if (p_wide < 0) begin
         press_sat = '0;
      end else if (p_wide > P_MAX) begin
         press_sat = '1;
      end else begin
         press_sat = p_wide[PRESS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         li_ff        <= '0;
         lj_ff        <= '0;
         pp_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pc_ff       <= pc_in;
         li_ff       <= li_in;
         lj_ff       <= lj_in;
         pp_valid_ff <= issue;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (q_ready && q_valid) begin
         delta_ff <= q_item.delta_t;
         press_ff <= q_item.press;
      end

      if (issue) begin
         pp_ff     <= pp_in;
         pp_neg_ff <= x_op.neg ^ y_op.neg;
         pp_clr_ff <= inst.clr && (li_ff == '0) && (lj_ff == '0);
         pp_sh_ff  <= inst.sh + {3'(li_ff + lj_ff), {LIMB_LOG{1'b0}}};
      end

      if (pp_valid_ff) begin
         acc_ff <= acc_in;
      end

      if (store) begin
         case (inst.dst)
            DST_DD: begin
               dd_ff     <= st_mag[63:0];
               dd_neg_ff <= st_neg;
            end
            DST_N: begin
               n_ff     <= st_mag[63:0];
               n_neg_ff <= st_neg;
               temp_ff  <= temp_sat;
            end
            DST_PSQ: begin
               psq_ff     <= st_mag[63:0];
               psq_neg_ff <= st_neg;
            end
            DST_PCUBE: begin
               pcube_ff     <= st_mag[95:0];
               pcube_neg_ff <= st_neg;
            end
            DST_H: begin
               h_ff     <= st_mag;
               h_neg_ff <= st_neg;
            end
            default: begin
            end
         endcase
      end

      if (finish) begin
         rsp_data_ff <= {press_sat, temp_ff};
      end
   end

endmodule

// File: rtl/barometric_pressure_compensation.sv
// The single 32x32 multiplier works through 40 partial products plus 8 store
//   steps of the program for each word; the sequencer takes no new word until
//   it has handed the previous result to the output register.
// Input stage and a two-entry queue take up to three further words meanwhile.
// Reset (synchronous, active high) empties all stages and clears calibration.
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: top level
// Calibration registers, input stage, queue and arithmetic sequencer.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation #(
   parameter int TEMP_FRAC_BITS  = 8,
   parameter int PRESS_FRAC_BITS = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bpc_pkg::REQ_W-1:0]     req_tdata,   // raw_pressure, raw_temperature
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bpc_pkg::RSP_W-1:0]     rsp_tdata,   // temperature_out, pressure_out
   input  logic                          csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpc_pkg::CSR_W-1:0]     csr_wdata
);
   import bpc_pkg::*;

   logic [CSR_W-1:0]      cal_low_ff, cal_mid_ff;
   logic [CAL_HIGH_W-1:0] cal_high_ff;
   logic [CAL_W-1:0]      cal_bytes;
   logic                  f_valid, f_ready, q_valid, q_ready;
   item_type              f_item, q_item;

   assign cal_bytes = {cal_high_ff, cal_mid_ff, cal_low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_low_ff  <= '0;
         cal_mid_ff  <= '0;
         cal_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOW:  cal_low_ff  <= csr_wdata;
            CSR_MID:  cal_mid_ff  <= csr_wdata;
            CSR_HIGH: cal_high_ff <= csr_wdata[CAL_HIGH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   bpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cal_t1     (cal_low_ff[15:0]),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .f_valid    (f_valid),
      .f_item     (f_item),
      .f_ready    (f_ready)
   );

   bpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   bpc_engine #(
      .TEMP_FRAC_BITS  (TEMP_FRAC_BITS),
      .PRESS_FRAC_BITS (PRESS_FRAC_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cal_bytes  (cal_bytes),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_ready    (q_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker: port-level checks
// Tracks words in flight and checks the response channel over time.
// ----------------------------------------------------------------------------
module bpc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [bpc_pkg::RSP_W-1:0] rsp_tdata
);
   import bpc_pkg::*;

   logic [2:0] inflight_ff, inflight_in;
   logic       req_hs, rsp_hs;

   assign req_hs = req_tvalid && req_tready;
   assign rsp_hs = rsp_tvalid && rsp_tready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_hs && !rsp_hs) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (rsp_hs && !req_hs) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != 3'd0)
      else $error("response word without a request word");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd5)
      else $error("more words in flight than storage");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);
